FILE: src/xbr_pkg.sv
package xbr_pkg;

   localparam int SMALL_BLOCK = 128;
   localparam int LARGE_BLOCK = 1024;
   localparam int POS_W       = 11;
   localparam int CSR_ADDR_W  = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_STX = 8'h02;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_CAN = 8'h18;
   localparam logic [7:0] CH_C   = 8'h43;

   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [15:0] CRC_HI_MASK = 16'hFF00;

   localparam logic [1:0] MODE_BYTE    = 2'd0;
   localparam logic [1:0] MODE_TIMEOUT = 2'd1;
   localparam logic [1:0] MODE_START   = 2'd2;

   localparam logic [1:0] KIND_REPLY   = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_VERDICT = 2'd2;
   localparam logic [1:0] KIND_END     = 2'd3;

   localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
   localparam logic [1:0] VERDICT_DUP    = 2'd1;
   localparam logic [1:0] VERDICT_REJECT = 2'd2;

   localparam logic END_EOT   = 1'b0;
   localparam logic END_ABORT = 1'b1;

   localparam logic [1:0] OPT_SUM  = 2'd0;
   localparam logic [1:0] OPT_CRC  = 2'd1;
   localparam logic [1:0] OPT_1K   = 2'd2;

   localparam logic [1:0] NUM_BAD  = 2'd0;
   localparam logic [1:0] NUM_EXP  = 2'd1;
   localparam logic [1:0] NUM_PREV = 2'd2;

   localparam logic [1:0] REG_BLOCK_OPTION = 2'd0;
   localparam logic [1:0] REG_CRC_CHECK    = 2'd1;
   localparam logic [1:0] REG_MAX_RETRIES  = 2'd2;

   localparam logic [1:0] RST_BLOCK_OPTION = 2'd1;
   localparam logic       RST_CRC_CHECK    = 1'b1;
   localparam logic [3:0] RST_MAX_RETRIES  = 4'd10;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_HEADER = 3'd1,
      PH_NUMBER = 3'd2,
      PH_COMPL  = 3'd3,
      PH_DATA   = 3'd4,
      PH_CHECK1 = 3'd5,
      PH_CHECK2 = 3'd6
   } phase_type;

   typedef struct packed {
      logic [1:0] block_option;
      logic       crc_check;
      logic [3:0] max_retries;
   } xbr_cfg_type;

   typedef struct packed {
      phase_type        phase;
      logic [POS_W-1:0] byte_position;
      logic             block_is_large;
      logic [7:0]       expected_block;
      logic [7:0]       received_number;
      logic [1:0]       number_ok;
      logic [7:0]       sum_accum;
      logic [15:0]      crc_accum;
      logic [7:0]       crc_high;
      logic [3:0]       retry_count;
      logic [1:0]       cancel_count;
      logic [31:0]      accepted_total;
   } xbr_state_type;

   localparam xbr_state_type STATE_RESET = '{
      phase:           PH_IDLE,
      byte_position:   '0,
      block_is_large:  1'b0,
      expected_block:  8'd1,
      received_number: 8'd0,
      number_ok:       NUM_BAD,
      sum_accum:       8'd0,
      crc_accum:       16'd0,
      crc_high:        8'd0,
      retry_count:     4'd0,
      cancel_count:    2'd0,
      accepted_total:  32'd0
   };

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic [1:0] verdict;
      logic       session_result;
   } xbr_result_type;

   // all results caused by one transaction
   typedef struct packed {
      logic [1:0]                last_idx;
      xbr_result_type [3:0]      res;
      logic [31:0]               total_bytes;
   } xbr_bundle_type;

   function automatic xbr_result_type make_result(logic [1:0] kind, logic [7:0] data_byte,
                                                  logic [1:0] verdict, logic session_result);
      xbr_result_type r;
      r.kind           = kind;
      r.data_byte      = data_byte;
      r.verdict        = verdict;
      r.session_result = session_result;
      return r;
   endfunction

   function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

FILE: src/xbr_req_if.sv
interface xbr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] rx_byte;

   modport source (output valid, output mode, output rx_byte, input ready);
   modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

FILE: src/xbr_rsp_if.sv
interface xbr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  data_byte;
   logic [1:0]  verdict;
   logic        session_result;
   logic [31:0] total_bytes;
   logic        last_result;

   modport source (output valid, output kind, output data_byte, output verdict,
                   output session_result, output total_bytes, output last_result,
                   input ready);
   modport sink (input valid, input kind, input data_byte, input verdict,
                 input session_result, input total_bytes, input last_result,
                 output ready);
endinterface

FILE: src/xbr_core.sv
module xbr_core #(
   parameter int SMALL_BLOCK = xbr_pkg::SMALL_BLOCK,
   parameter int LARGE_BLOCK = xbr_pkg::LARGE_BLOCK
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  logic [1:0]              mode,
   input  logic [7:0]              rx_byte,
   input  xbr_pkg::xbr_cfg_type    cfg,
   output xbr_pkg::xbr_bundle_type bundle,
   output logic                    has_result
);

   localparam int POS_W_L = xbr_pkg::POS_W;
   localparam logic [POS_W_L-1:0] SMALL_LEN = POS_W_L'(SMALL_BLOCK);
   localparam logic [POS_W_L-1:0] LARGE_LEN = POS_W_L'(LARGE_BLOCK);

   xbr_pkg::xbr_state_type state_ff;
   xbr_pkg::xbr_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xbr_pkg::STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      xbr_pkg::xbr_state_type st;
      xbr_pkg::xbr_result_type [3:0] res;
      logic [2:0]  n;
      logic        do_fail;
      logic        fail_send;
      logic [7:0]  fail_reply;
      logic        do_verdict;
      logic        check_ok;
      logic        do_abort;
      logic [4:0]  next_retry;
      logic [32:0] total_sum;
      logic [7:0]  prev_block;
      logic [POS_W_L-1:0] pos_next;

      st         = state_ff;
      res        = '0;
      n          = 3'd0;
      do_fail    = 1'b0;
      fail_send  = 1'b0;
      fail_reply = xbr_pkg::CH_NAK;
      do_verdict = 1'b0;
      check_ok   = 1'b0;
      do_abort   = 1'b0;
      next_retry = 5'd0;
      total_sum  = 33'd0;
      prev_block = state_ff.expected_block - 8'd1;
      pos_next   = state_ff.byte_position + POS_W_L'(1);

      case (mode)
         xbr_pkg::MODE_START: begin
            st = xbr_pkg::STATE_RESET;
            st.phase = xbr_pkg::PH_HEADER;
            res[n[1:0]] = xbr_pkg::make_result(xbr_pkg::KIND_REPLY,
               (cfg.block_option inside {xbr_pkg::OPT_CRC, xbr_pkg::OPT_1K}) ?
               xbr_pkg::CH_C : xbr_pkg::CH_NAK, xbr_pkg::VERDICT_ACCEPT, xbr_pkg::END_EOT);
            n = n + 3'd1;
         end
         xbr_pkg::MODE_TIMEOUT: begin
            if (state_ff.phase == xbr_pkg::PH_HEADER) begin
               do_fail = 1'b1;
            end else if (state_ff.phase != xbr_pkg::PH_IDLE) begin
               res[n[1:0]] = xbr_pkg::make_result(xbr_pkg::KIND_VERDICT, 8'd0,
                  xbr_pkg::VERDICT_REJECT, xbr_pkg::END_EOT);
               n = n + 3'd1;
               do_fail   = 1'b1;
               fail_send = 1'b1;
            end
         end
         xbr_pkg::MODE_BYTE: begin
            case (state_ff.phase)
               xbr_pkg::PH_IDLE: begin
               end
               xbr_pkg::PH_HEADER: begin
                  if (rx_byte == xbr_pkg::CH_SOH ||
                      (rx_byte == xbr_pkg::CH_STX && cfg.block_option == xbr_pkg::OPT_1K)) begin
                     st.cancel_count   = 2'd0;
                     st.block_is_large = (rx_byte == xbr_pkg::CH_STX);
                     st.byte_position  = '0;
                     st.number_ok      = xbr_pkg::NUM_BAD;
                     st.sum_accum      = 8'd0;
                     st.crc_accum      = 16'd0;
                     st.phase          = xbr_pkg::PH_NUMBER;
                  end else if (rx_byte == xbr_pkg::CH_STX) begin
                     st.cancel_count = 2'd0;
                     do_fail   = 1'b1;
                     fail_send = 1'b1;
                  end else if (rx_byte == xbr_pkg::CH_EOT) begin
                     st.cancel_count = 2'd0;
                     res[n[1:0]] = xbr_pkg::make_result(xbr_pkg::KIND_REPLY,
                        xbr_pkg::CH_ACK, xbr_pkg::VERDICT_ACCEPT, xbr_pkg::END_EOT);
                     n = n + 3'd1;
                     res[n[1:0]] = xbr_pkg::make_result(xbr_pkg::KIND_END, 8'd0,
                        xbr_pkg::VERDICT_ACCEPT, xbr_pkg::END_EOT);
                     n = n + 3'd1;
                     st.phase = xbr_pkg::PH_IDLE;
                  end else if (rx_byte == xbr_pkg::CH_CAN) begin
                     if (state_ff.cancel_count + 2'd1 >= 2'd2) begin
                        st.cancel_count = 2'd0;
                        do_abort = 1'b1;
                     end else begin
                        st.cancel_count = state_ff.cancel_count + 2'd1;
                        do_fail   = 1'b1;
                        fail_send = 1'b1;
                     end
                  end else begin
                     do_fail   = 1'b1;
                     fail_send = 1'b1;
                  end
               end
               xbr_pkg::PH_NUMBER: begin
                  st.received_number = rx_byte;
                  st.phase = xbr_pkg::PH_COMPL;
               end
               xbr_pkg::PH_COMPL: begin
                  if (state_ff.received_number == state_ff.expected_block &&
                      rx_byte == ~state_ff.expected_block) begin
                     st.number_ok = xbr_pkg::NUM_EXP;
                  end else if (state_ff.received_number == prev_block &&
                               rx_byte == ~prev_block) begin
                     st.number_ok = xbr_pkg::NUM_PREV;
                  end else begin
                     st.number_ok = xbr_pkg::NUM_BAD;
                  end
                  st.byte_position = '0;
                  st.phase = xbr_pkg::PH_DATA;
               end
               xbr_pkg::PH_DATA: begin
                  res[n[1:0]] = xbr_pkg::make_result(xbr_pkg::KIND_PAYLOAD, rx_byte,
                     xbr_pkg::VERDICT_ACCEPT, xbr_pkg::END_EOT);
                  n = n + 3'd1;
                  st.sum_accum     = state_ff.sum_accum + rx_byte;
                  st.crc_accum     = xbr_pkg::crc16_byte(state_ff.crc_accum, rx_byte);
                  st.byte_position = pos_next;
                  if (pos_next >= (state_ff.block_is_large ? LARGE_LEN : SMALL_LEN)) begin
                     st.phase = xbr_pkg::PH_CHECK1;
                  end
               end
               xbr_pkg::PH_CHECK1: begin
                  if (cfg.crc_check || state_ff.block_is_large) begin
                     st.crc_high = rx_byte;
                     st.phase = xbr_pkg::PH_CHECK2;
                  end else begin
                     do_verdict = 1'b1;
                     check_ok   = (rx_byte == state_ff.sum_accum);
                  end
               end
               default: begin
                  do_verdict = 1'b1;
                  check_ok   = (state_ff.crc_high ==
                                8'((state_ff.crc_accum & xbr_pkg::CRC_HI_MASK) >> 8)) &&
                               (rx_byte == state_ff.crc_accum[7:0]);
               end
            endcase
         end
         default: begin
         end
      endcase

      if (do_verdict) begin
         if (state_ff.number_ok == xbr_pkg::NUM_EXP && check_ok) begin
            total_sum = {1'b0, state_ff.accepted_total} +
                        (state_ff.block_is_large ? 33'(LARGE_BLOCK) : 33'(SMALL_BLOCK));
            st.accepted_total = total_sum[32] ? '1 : total_sum[31:0];
            st.expected_block = state_ff.expected_block + 8'd1;
            st.retry_count    = 4'd0;
            res[n[1:0]] = xbr_pkg::make_result(xbr_pkg::KIND_VERDICT, 8'd0,
               xbr_pkg::VERDICT_ACCEPT, xbr_pkg::END_EOT);
            n = n + 3'd1;
            res[n[1:0]] = xbr_pkg::make_result(xbr_pkg::KIND_REPLY, xbr_pkg::CH_ACK,
               xbr_pkg::VERDICT_ACCEPT, xbr_pkg::END_EOT);
            n = n + 3'd1;
            st.phase = xbr_pkg::PH_HEADER;
         end else if (state_ff.number_ok == xbr_pkg::NUM_PREV) begin
            res[n[1:0]] = xbr_pkg::make_result(xbr_pkg::KIND_VERDICT, 8'd0,
               xbr_pkg::VERDICT_DUP, xbr_pkg::END_EOT);
            n = n + 3'd1;
            do_fail    = 1'b1;
            fail_send  = 1'b1;
            fail_reply = xbr_pkg::CH_ACK;
         end else begin
            res[n[1:0]] = xbr_pkg::make_result(xbr_pkg::KIND_VERDICT, 8'd0,
               xbr_pkg::VERDICT_REJECT, xbr_pkg::END_EOT);
            n = n + 3'd1;
            do_fail   = 1'b1;
            fail_send = 1'b1;
         end
      end

      if (do_fail) begin
         next_retry = {1'b0, state_ff.retry_count} + 5'd1;
         if (next_retry >= {1'b0, cfg.max_retries}) begin
            st.retry_count = 4'd0;
            do_abort = 1'b1;
         end else begin
            st.retry_count = next_retry[3:0];
            if (fail_send) begin
               res[n[1:0]] = xbr_pkg::make_result(xbr_pkg::KIND_REPLY, fail_reply,
                  xbr_pkg::VERDICT_ACCEPT, xbr_pkg::END_EOT);
               n = n + 3'd1;
            end
            st.phase = xbr_pkg::PH_HEADER;
         end
      end

      if (do_abort) begin
         res[n[1:0]] = xbr_pkg::make_result(xbr_pkg::KIND_REPLY, xbr_pkg::CH_CAN,
            xbr_pkg::VERDICT_ACCEPT, xbr_pkg::END_EOT);
         n = n + 3'd1;
         res[n[1:0]] = xbr_pkg::make_result(xbr_pkg::KIND_REPLY, xbr_pkg::CH_CAN,
            xbr_pkg::VERDICT_ACCEPT, xbr_pkg::END_EOT);
         n = n + 3'd1;
         res[n[1:0]] = xbr_pkg::make_result(xbr_pkg::KIND_END, 8'd0,
            xbr_pkg::VERDICT_ACCEPT, xbr_pkg::END_ABORT);
         n = n + 3'd1;
         st.phase = xbr_pkg::PH_IDLE;
      end

      state_in           = fire ? st : state_ff;
      bundle.res         = res;
      bundle.last_idx    = 2'(n - 3'd1);
      bundle.total_bytes = st.accepted_total;
      has_result         = (n != 3'd0);
   end

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      fire && has_result && bundle.res[bundle.last_idx].kind != xbr_pkg::KIND_END |->
      bundle.res[0].kind != xbr_pkg::KIND_END && bundle.res[1].kind != xbr_pkg::KIND_END &&
      bundle.res[2].kind != xbr_pkg::KIND_END && bundle.res[3].kind != xbr_pkg::KIND_END)
      else $error("session end not last result of transaction");

   a_idle_after_end: assert property (@(posedge clock) disable iff (reset)
      fire && has_result && bundle.res[bundle.last_idx].kind == xbr_pkg::KIND_END |=>
      state_ff.phase == xbr_pkg::PH_IDLE)
      else $error("session end left phase active");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.byte_position <= LARGE_LEN)
      else $error("byte position beyond large block");

endmodule

FILE: src/xmodem_block_receiver.sv
// Path: a transaction is registered in the input stage at acceptance; its results are written
// into the result queue once the queue has room, and are offered from the queue head.
// Throughput: one input transaction per cycle while each yields at most one result and the
// output is ready; the output port moves one result per cycle while ready, in order.
// Reset (synchronous): session idle, expected block 1, totals cleared, queued results
// dropped, block_option 1, crc_check 1, max_retries 10.
module xmodem_block_receiver #(
   parameter int SMALL_BLOCK = xbr_pkg::SMALL_BLOCK,
   parameter int LARGE_BLOCK = xbr_pkg::LARGE_BLOCK
) (
   input  logic                             clock,
   input  logic                             reset,
   xbr_req_if.sink                          req_chan,
   xbr_rsp_if.source                        rsp_chan,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [xbr_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   xbr_pkg::xbr_cfg_type cfg_ff;
   logic                 cfg_write;

   logic       stage_valid_ff;
   logic [1:0] stage_mode_ff;
   logic [7:0] stage_byte_ff;

   xbr_pkg::xbr_bundle_type queue_ff [xbr_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] sub_idx_ff;

   xbr_pkg::xbr_bundle_type bundle;
   xbr_pkg::xbr_bundle_type head;
   xbr_pkg::xbr_result_type head_res;
   logic has_result;
   logic fire;
   logic push;
   logic pop;
   logic out_take;
   logic out_last;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_option <= xbr_pkg::RST_BLOCK_OPTION;
         cfg_ff.crc_check    <= xbr_pkg::RST_CRC_CHECK;
         cfg_ff.max_retries  <= xbr_pkg::RST_MAX_RETRIES;
      end else if (cfg_write) begin
         case (paddr[3:2])
            xbr_pkg::REG_BLOCK_OPTION: cfg_ff.block_option <= pwdata[1:0];
            xbr_pkg::REG_CRC_CHECK:    cfg_ff.crc_check    <= pwdata[0];
            xbr_pkg::REG_MAX_RETRIES:  cfg_ff.max_retries  <= pwdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         xbr_pkg::REG_BLOCK_OPTION: prdata = {30'd0, cfg_ff.block_option};
         xbr_pkg::REG_CRC_CHECK:    prdata = {31'd0, cfg_ff.crc_check};
         xbr_pkg::REG_MAX_RETRIES:  prdata = {28'd0, cfg_ff.max_retries};
         default:                   prdata = 32'd0;
      endcase
   end

   // input stage
   assign fire           = stage_valid_ff && (count_ff != 2'(xbr_pkg::QUEUE_DEPTH) || pop);
   assign req_chan.ready = !stage_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         stage_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         stage_mode_ff <= req_chan.mode;
         stage_byte_ff <= req_chan.rx_byte;
      end
   end

   xbr_core #(
      .SMALL_BLOCK (SMALL_BLOCK),
      .LARGE_BLOCK (LARGE_BLOCK)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .mode       (stage_mode_ff),
      .rx_byte    (stage_byte_ff),
      .cfg        (cfg_ff),
      .bundle     (bundle),
      .has_result (has_result)
   );

   // result queue, one entry per transaction that yields results
   assign push     = fire && has_result;
   assign head     = queue_ff[rd_ptr_ff];
   assign head_res = head.res[sub_idx_ff];
   assign out_last = (sub_idx_ff == head.last_idx);
   assign out_take = rsp_chan.valid && rsp_chan.ready;
   assign pop      = out_take && out_last;

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= 1'b0;
         rd_ptr_ff  <= 1'b0;
         count_ff   <= 2'd0;
         sub_idx_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
         if (out_take) begin
            sub_idx_ff <= out_last ? 2'd0 : sub_idx_ff + 2'd1;
         end
      end
   end

   assign rsp_chan.valid          = (count_ff != 2'd0);
   assign rsp_chan.kind           = head_res.kind;
   assign rsp_chan.data_byte      = head_res.data_byte;
   assign rsp_chan.verdict        = head_res.verdict;
   assign rsp_chan.session_result = head_res.session_result;
   assign rsp_chan.total_bytes    = head.total_bytes;
   assign rsp_chan.last_result    = out_last;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(xbr_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   a_sub_idx_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> sub_idx_ff <= head.last_idx)
      else $error("result index past end of transaction");

   a_end_marks_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.kind == xbr_pkg::KIND_END |-> rsp_chan.last_result)
      else $error("session end not marked last");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid && !stage_valid_ff)
      else $error("results survive reset");

endmodule

FILE: test/xmodem_block_receiver_tb.sv
module xmodem_block_receiver_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD = 400;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] rx_byte;
   } event_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [1:0]  verdict;
      logic        session_result;
      logic [31:0] total_bytes;
      logic        last_result;
   } reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [xbr_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   xbr_req_if req_bus();
   xbr_rsp_if rsp_bus();

   xmodem_block_receiver dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   event_type pending[$];
   reply_type expected_q[$];

   int idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int holds_done = 0;
   int hold_left = 0;
   int idle_cycles = 0;
   int fail_count = 0;
   int n_accepted = 0;
   int n_results = 0;
   int n_ok = 0;
   int n_dup = 0;
   int n_rej = 0;
   int n_ends = 0;

   // receiver model state
   logic [1:0]         cfg_opt = xbr_pkg::RST_BLOCK_OPTION;
   logic               cfg_crc = xbr_pkg::RST_CRC_CHECK;
   logic [3:0]         cfg_retry_max = xbr_pkg::RST_MAX_RETRIES;
   xbr_pkg::phase_type st_phase = xbr_pkg::PH_IDLE;
   logic [10:0]        st_pos = '0;
   logic               st_large = 1'b0;
   logic [7:0]         st_expect_blk = 8'd1;
   logic [7:0]         st_rx_num = '0;
   logic [1:0]         st_num_ok = xbr_pkg::NUM_BAD;
   logic [7:0]         st_sum = '0;
   logic [15:0]        st_crc = '0;
   logic [7:0]         st_crc_hi = '0;
   logic [3:0]         st_retries = '0;
   logic [1:0]         st_cancels = '0;
   logic [31:0]        st_total = '0;
   reply_type          outs[4];
   int                 n_out;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      repeat (8) r = r[15] ? ({r[14:0], 1'b0} ^ xbr_pkg::CRC_POLY) : {r[14:0], 1'b0};
      return r;
   endfunction

   function automatic void put(logic [1:0] k, logic [7:0] d, logic [1:0] v, logic s);
      if (n_out < 4) begin
         outs[n_out] = '{k, d, v, s, 32'd0, 1'b0};
         n_out++;
      end
   endfunction

   function automatic void abort_session();
      put(xbr_pkg::KIND_REPLY, xbr_pkg::CH_CAN, xbr_pkg::VERDICT_ACCEPT, xbr_pkg::END_EOT);
      put(xbr_pkg::KIND_REPLY, xbr_pkg::CH_CAN, xbr_pkg::VERDICT_ACCEPT, xbr_pkg::END_EOT);
      put(xbr_pkg::KIND_END, 8'h00, xbr_pkg::VERDICT_ACCEPT, xbr_pkg::END_ABORT);
      st_phase = xbr_pkg::PH_IDLE;
   endfunction

   function automatic void note_failure(bit send, logic [7:0] reply);
      int n;
      n = st_retries + 1;
      if (n >= cfg_retry_max) begin
         st_retries = '0;
         abort_session();
         return;
      end
      st_retries = n[3:0];
      if (send) put(xbr_pkg::KIND_REPLY, reply, xbr_pkg::VERDICT_ACCEPT, xbr_pkg::END_EOT);
      st_phase = xbr_pkg::PH_HEADER;
   endfunction

   function automatic void judge(bit check_ok);
      logic [32:0] t;
      if (st_num_ok == xbr_pkg::NUM_EXP && check_ok) begin
         t = {1'b0, st_total} +
             33'(st_large ? xbr_pkg::LARGE_BLOCK : xbr_pkg::SMALL_BLOCK);
         st_total = t[32] ? '1 : t[31:0];
         st_expect_blk = st_expect_blk + 8'd1;
         st_retries = '0;
         put(xbr_pkg::KIND_VERDICT, 8'h00, xbr_pkg::VERDICT_ACCEPT, xbr_pkg::END_EOT);
         put(xbr_pkg::KIND_REPLY, xbr_pkg::CH_ACK, xbr_pkg::VERDICT_ACCEPT, xbr_pkg::END_EOT);
         st_phase = xbr_pkg::PH_HEADER;
      end else if (st_num_ok == xbr_pkg::NUM_PREV) begin
         put(xbr_pkg::KIND_VERDICT, 8'h00, xbr_pkg::VERDICT_DUP, xbr_pkg::END_EOT);
         note_failure(1'b1, xbr_pkg::CH_ACK);
      end else begin
         put(xbr_pkg::KIND_VERDICT, 8'h00, xbr_pkg::VERDICT_REJECT, xbr_pkg::END_EOT);
         note_failure(1'b1, xbr_pkg::CH_NAK);
      end
   endfunction

   function automatic void open_block(logic big_blk);
      st_cancels = '0;
      st_large = big_blk;
      st_pos = '0;
      st_num_ok = xbr_pkg::NUM_BAD;
      st_sum = '0;
      st_crc = '0;
      st_phase = xbr_pkg::PH_NUMBER;
   endfunction

   // expected results of one accepted transaction
   function automatic void model_step(logic [1:0] mode, logic [7:0] b);
      logic [7:0] prev;
      prev = st_expect_blk - 8'd1;
      n_out = 0;
      case (mode)
         xbr_pkg::MODE_START: begin
            st_phase = xbr_pkg::PH_HEADER;
            st_pos = '0;
            st_large = 1'b0;
            st_expect_blk = 8'd1;
            st_rx_num = '0;
            st_num_ok = xbr_pkg::NUM_BAD;
            st_sum = '0;
            st_crc = '0;
            st_crc_hi = '0;
            st_retries = '0;
            st_cancels = '0;
            st_total = '0;
            put(xbr_pkg::KIND_REPLY,
                (cfg_opt == xbr_pkg::OPT_CRC || cfg_opt == xbr_pkg::OPT_1K) ?
                xbr_pkg::CH_C : xbr_pkg::CH_NAK,
                xbr_pkg::VERDICT_ACCEPT, xbr_pkg::END_EOT);
         end
         xbr_pkg::MODE_TIMEOUT: begin
            if (st_phase == xbr_pkg::PH_HEADER) begin
               note_failure(1'b0, xbr_pkg::CH_NAK);
            end else if (st_phase != xbr_pkg::PH_IDLE) begin
               put(xbr_pkg::KIND_VERDICT, 8'h00, xbr_pkg::VERDICT_REJECT, xbr_pkg::END_EOT);
               note_failure(1'b1, xbr_pkg::CH_NAK);
            end
         end
         xbr_pkg::MODE_BYTE: begin
            if (st_phase == xbr_pkg::PH_HEADER) begin
               if (b == xbr_pkg::CH_SOH) begin
                  open_block(1'b0);
               end else if (b == xbr_pkg::CH_STX) begin
                  st_cancels = '0;
                  if (cfg_opt == xbr_pkg::OPT_1K) open_block(1'b1);
                  else note_failure(1'b1, xbr_pkg::CH_NAK);
               end else if (b == xbr_pkg::CH_EOT) begin
                  st_cancels = '0;
                  put(xbr_pkg::KIND_REPLY, xbr_pkg::CH_ACK, xbr_pkg::VERDICT_ACCEPT,
                      xbr_pkg::END_EOT);
                  put(xbr_pkg::KIND_END, 8'h00, xbr_pkg::VERDICT_ACCEPT, xbr_pkg::END_EOT);
                  st_phase = xbr_pkg::PH_IDLE;
               end else if (b == xbr_pkg::CH_CAN) begin
                  st_cancels = st_cancels + 2'd1;
                  if (st_cancels >= 2) begin
                     st_cancels = '0;
                     abort_session();
                  end else begin
                     note_failure(1'b1, xbr_pkg::CH_NAK);
                  end
               end else begin
                  note_failure(1'b1, xbr_pkg::CH_NAK);
               end
            end else if (st_phase != xbr_pkg::PH_IDLE) begin
               case (st_phase)
                  xbr_pkg::PH_NUMBER: begin
                     st_rx_num = b;
                     st_phase = xbr_pkg::PH_COMPL;
                  end
                  xbr_pkg::PH_COMPL: begin
                     if (st_rx_num == st_expect_blk && b == ~st_expect_blk)
                        st_num_ok = xbr_pkg::NUM_EXP;
                     else if (st_rx_num == prev && b == ~prev)
                        st_num_ok = xbr_pkg::NUM_PREV;
                     else
                        st_num_ok = xbr_pkg::NUM_BAD;
                     st_pos = '0;
                     st_phase = xbr_pkg::PH_DATA;
                  end
                  xbr_pkg::PH_DATA: begin
                     put(xbr_pkg::KIND_PAYLOAD, b, xbr_pkg::VERDICT_ACCEPT, xbr_pkg::END_EOT);
                     st_sum = st_sum + b;
                     st_crc = crc_step(st_crc, b);
                     st_pos = st_pos + 11'd1;
                     if (st_pos >= 11'(st_large ? xbr_pkg::LARGE_BLOCK : xbr_pkg::SMALL_BLOCK))
                        st_phase = xbr_pkg::PH_CHECK1;
                  end
                  xbr_pkg::PH_CHECK1: begin
                     if (cfg_crc || st_large) begin
                        st_crc_hi = b;
                        st_phase = xbr_pkg::PH_CHECK2;
                     end else begin
                        judge(b == st_sum);
                     end
                  end
                  default: judge(st_crc_hi == st_crc[15:8] && b == st_crc[7:0]);
               endcase
            end
         end
         default: ;
      endcase
      for (int k = 0; k < n_out; k++) begin
         outs[k].total_bytes = st_total;
         outs[k].last_result = (k == n_out - 1);
         expected_q.push_back(outs[k]);
      end
   endfunction

   // stimulus builders
   function automatic void add(logic [1:0] mode, logic [7:0] b);
      pending.push_back('{mode, b});
   endfunction

   // cut_at below zero or past the last data byte sends the whole block, else a timeout replaces data byte cut_at
   function automatic void add_block(logic [7:0] num, logic big_blk, bit bad_compl,
                                     int cut_at);
      logic [15:0] crc;
      logic [7:0] sum;
      logic [7:0] b;
      int len;
      crc = '0;
      sum = '0;
      len = big_blk ? xbr_pkg::LARGE_BLOCK : xbr_pkg::SMALL_BLOCK;
      add(xbr_pkg::MODE_BYTE, big_blk ? xbr_pkg::CH_STX : xbr_pkg::CH_SOH);
      add(xbr_pkg::MODE_BYTE, num);
      add(xbr_pkg::MODE_BYTE, bad_compl ? num : ~num);
      for (int i = 0; i < len; i++) begin
         if (i == cut_at) begin
            add(xbr_pkg::MODE_TIMEOUT, 8'($urandom));
            return;
         end
         b = 8'($urandom);
         add(xbr_pkg::MODE_BYTE, b);
         sum = sum + b;
         crc = crc_step(crc, b);
      end
      if (cfg_crc || big_blk) begin
         add(xbr_pkg::MODE_BYTE, crc[15:8]);
         add(xbr_pkg::MODE_BYTE, crc[7:0]);
      end else begin
         add(xbr_pkg::MODE_BYTE, sum);
      end
   endfunction

   function automatic void add_session(int n_events);
      logic [7:0] num;
      logic big_blk;
      int r;
      add(xbr_pkg::MODE_START, 8'($urandom));
      repeat (n_events) begin
         r = $urandom_range(99);
         if (r < 15) begin
            add(xbr_pkg::MODE_BYTE, 8'($urandom));
         end else if (r < 25) begin
            add(xbr_pkg::MODE_TIMEOUT, 8'($urandom));
         end else if (r < 35) begin
            add(xbr_pkg::MODE_BYTE, xbr_pkg::CH_CAN);
         end else if (r < 40) begin
            add(MODE_UNUSED, 8'($urandom));
         end else begin
            big_blk = (cfg_opt == xbr_pkg::OPT_1K) && ($urandom_range(1) == 0);
            r = $urandom_range(99);
            num = (r < 70) ? 8'd1 : (r < 85) ? 8'd0 : 8'($urandom);
            add_block(num, big_blk, $urandom_range(3) == 0, int'($urandom_range(1, 4)));
         end
      end
      if ($urandom_range(3) != 0) add(xbr_pkg::MODE_BYTE, xbr_pkg::CH_EOT);
   endfunction

   // bus tasks
   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      case (idx)
         xbr_pkg::REG_BLOCK_OPTION: cfg_opt = val[1:0];
         xbr_pkg::REG_CRC_CHECK:    cfg_crc = val[0];
         xbr_pkg::REG_MAX_RETRIES:  cfg_retry_max = val[3:0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [1:0] opt, logic crc, logic [3:0] max_retries);
      write_csr(xbr_pkg::REG_BLOCK_OPTION, 32'(opt));
      write_csr(xbr_pkg::REG_CRC_CHECK, 32'(crc));
      write_csr(xbr_pkg::REG_MAX_RETRIES, 32'(max_retries));
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pending.size() != 0 || req_bus.valid || expected_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      event_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            model_step(req_bus.mode, req_bus.rx_byte);
            n_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
               nxt = pending.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.mode <= nxt.mode;
               req_bus.rx_byte <= nxt.rx_byte;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_done < hold_requests) begin
         hold_left <= LONG_HOLD;
         holds_done <= holds_done + 1;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // monitor
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         n_results++;
         if (expected_q.size() == 0) begin
            $error("unexpected result: kind %0d data %0h", rsp_bus.kind, rsp_bus.data_byte);
            fail_count++;
         end else begin
            want = expected_q.pop_front();
            check_field("kind", want.kind, rsp_bus.kind);
            check_field("data_byte", want.data_byte, rsp_bus.data_byte);
            check_field("verdict", want.verdict, rsp_bus.verdict);
            check_field("session_result", want.session_result, rsp_bus.session_result);
            check_field("total_bytes", want.total_bytes, rsp_bus.total_bytes);
            check_field("last_result", want.last_result, rsp_bus.last_result);
            if (want.kind == xbr_pkg::KIND_END) n_ends++;
            if (want.kind == xbr_pkg::KIND_VERDICT) begin
               case (want.verdict)
                  xbr_pkg::VERDICT_ACCEPT: n_ok++;
                  xbr_pkg::VERDICT_DUP:    n_dup++;
                  default:                 n_rej++;
               endcase
            end
         end
      end
   end

   // watchdog on transaction progress
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (pending.size() == 0 && !req_bus.valid && expected_q.size() == 0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                  idle_cycles, expected_q.size());
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.mode = xbr_pkg::MODE_BYTE;
      req_bus.rx_byte = 8'h00;
      rsp_bus.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed, reset configuration
      add(xbr_pkg::MODE_BYTE, 8'h00);
      add(xbr_pkg::MODE_TIMEOUT, 8'hFF);
      add(MODE_UNUSED, 8'hFF);
      add(xbr_pkg::MODE_START, 8'h00);
      add(xbr_pkg::MODE_TIMEOUT, 8'h00);
      add(xbr_pkg::MODE_BYTE, 8'hFF);
      add(xbr_pkg::MODE_BYTE, 8'h00);
      add(xbr_pkg::MODE_BYTE, xbr_pkg::CH_CAN);
      add(xbr_pkg::MODE_BYTE, xbr_pkg::CH_CAN);
      add(MODE_UNUSED, 8'h00);
      add(xbr_pkg::MODE_START, 8'hFF);
      add(xbr_pkg::MODE_BYTE, xbr_pkg::CH_STX);
      add(xbr_pkg::MODE_BYTE, xbr_pkg::CH_CAN);
      add(xbr_pkg::MODE_BYTE, xbr_pkg::CH_SOH);
      add(xbr_pkg::MODE_BYTE, 8'h01);
      add(xbr_pkg::MODE_BYTE, 8'hFE);
      add(xbr_pkg::MODE_BYTE, 8'h00);
      add(xbr_pkg::MODE_BYTE, 8'hFF);
      add(xbr_pkg::MODE_TIMEOUT, 8'h55);
      add(xbr_pkg::MODE_BYTE, xbr_pkg::CH_EOT);
      add(xbr_pkg::MODE_START, 8'hAA);
      add(xbr_pkg::MODE_START, 8'h55);
      add(xbr_pkg::MODE_BYTE, xbr_pkg::CH_SOH);
      add(xbr_pkg::MODE_TIMEOUT, 8'h00);
      add(xbr_pkg::MODE_BYTE, xbr_pkg::CH_EOT);
      drain();

      // one full crc block, sender idling
      set_config(xbr_pkg::OPT_CRC, 1'b1, 4'd15);
      idle_pct = 65;
      stall_pct = 0;
      add(xbr_pkg::MODE_START, 8'h00);
      add_block(8'd1, 1'b0, 1'b0, -1);
      add(xbr_pkg::MODE_BYTE, xbr_pkg::CH_EOT);
      drain();

      // 1k allowed, receiver stalling, with one long hold-off
      set_config(xbr_pkg::OPT_1K, 1'b0, 4'd3);
      idle_pct = 0;
      stall_pct = 65;
      hold_requests++;
      add(xbr_pkg::MODE_START, 8'h00);
      add(xbr_pkg::MODE_BYTE, 8'h33);
      add(xbr_pkg::MODE_BYTE, 8'h44);
      add(xbr_pkg::MODE_BYTE, xbr_pkg::CH_CAN);
      add_session(2);
      drain();

      // checksum preamble, single failure aborts, both sides idling
      set_config(xbr_pkg::OPT_SUM, 1'b0, 4'd1);
      idle_pct = 34;
      stall_pct = 34;
      add_session(2);
      drain();

      repeat (10) @(posedge clock);
      $display("Ran %0d transactions in, %0d results out, %0d sessions ended.",
               n_accepted, n_results, n_ends);
      $display("Block verdicts: %0d accepted, %0d duplicate, %0d rejected.", n_ok, n_dup, n_rej);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
